/* sv/mesh_flood_relay_filter_top_assert.svh */
// Assertion macros for the mesh flood relay filter.
// Used by the datapath; expects clk and rst_n in scope.
`ifndef MESH_FLOOD_RELAY_FILTER_TOP_ASSERT_SVH
`define MESH_FLOOD_RELAY_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define MFRF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfrf assertion failed");

// next-cycle implication
`define MFRF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfrf assertion failed");

`endif

/* sv/mfrf_pkg.sv */
// Shared types and constants for the mesh flood relay filter.
// No dependencies.
package mfrf_pkg;

    localparam int SEEN_DEPTH_DEF = 32;
    localparam int ID_W           = 32;
    localparam int ADDR_W         = 48;

    localparam logic [7:0]        PROTO_VERSION = 8'h01;
    localparam logic [7:0]        HOP_MAX       = 8'hFF;
    localparam logic [ADDR_W-1:0] ADDR_BCAST    = '1;

    localparam logic [2:0] T_DATA      = 3'd0;
    localparam logic [2:0] T_FORWARD   = 3'd1;
    localparam logic [2:0] T_EMERGENCY = 3'd2;
    localparam logic [2:0] T_ACK       = 3'd3;
    localparam logic [2:0] T_HEARTBEAT = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_VERSION = 3'd1;
    localparam logic [2:0] ST_AUTH_FAIL   = 3'd2;
    localparam logic [2:0] ST_DUPLICATE   = 3'd3;
    localparam logic [2:0] ST_LOCAL       = 3'd4;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_RECORD   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/mfrf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/mfrf_ctrl.sv */
// Controller state machine: accept, scan the seen store, drain, load result.
// Depends on mfrf_pkg.
module mfrf_ctrl
    import mfrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dp_status.need_scan ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN:
            begin
                if (dp_status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (dp_status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready              = 1'b0;
        dp_cmd.capture        = 1'b0;
        dp_cmd.scan_step      = 1'b0;
        dp_cmd.load_result    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready       = 1'b1;
                dp_cmd.capture = in_valid;
            end
            S_SCAN:
            begin
                dp_cmd.scan_step = 1'b1;
            end
            S_DRAIN:
            begin
            end
            S_RESULT:
            begin
                dp_cmd.load_result = dp_status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* sv/mfrf_dp.sv */
// Datapath: header capture, seen-id store and scan, classification, result register.
// Depends on mfrf_pkg, mfrf_ram and the assertion macro header.
`include "mesh_flood_relay_filter_top_assert.svh"

module mfrf_dp
    import mfrf_pkg::*;
#(
    parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           dp_cmd,
    output dp_status_t        dp_status,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    input  logic              operation,
    input  logic [ID_W-1:0]   message_id,
    input  logic [7:0]        version,
    input  logic              auth_ok,
    input  logic [2:0]        msg_type,
    input  logic [ADDR_W-1:0] origin_addr,
    input  logic [ADDR_W-1:0] dest_addr,
    input  logic [7:0]        hop_limit,
    input  logic [7:0]        hops_taken,
    input  logic              ack_request,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic              deliver,
    output logic              send_ack,
    output logic              relay,
    output logic [7:0]        relay_hop_limit,
    output logic [7:0]        relay_hops,
    output logic              ack_for_us,
    output logic              heartbeat_seen
);

    localparam int AW = $clog2(SEEN_DEPTH);
    localparam int FW = $clog2(SEEN_DEPTH + 1);

    logic [ADDR_W-1:0] my_addr_reg;
    logic              op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [7:0]        ver_reg;
    logic              auth_reg;
    logic [2:0]        type_reg;
    logic [ADDR_W-1:0] origin_reg;
    logic [ADDR_W-1:0] dest_reg;
    logic [7:0]        limit_reg;
    logic [7:0]        hops_reg;
    logic              ackreq_reg;

    logic [AW-1:0]     slot_reg, slot_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     cmp_idx_reg;
    logic              cmp_valid_reg;
    logic              hit_reg, hit_next;
    logic              out_valid_reg, out_valid_next;

    logic [2:0]        status_reg;
    logic              deliver_reg, send_ack_reg, relay_reg, ack_us_reg, hb_reg;
    logic [7:0]        r_limit_reg, r_hops_reg;

    logic [ID_W-1:0]   rdata;
    logic              entry_match;
    logic              record;
    logic              may_relay;
    logic              to_me, to_bcast;
    logic [2:0]        st_c;
    logic              deliver_c, send_ack_c, relay_c, ack_us_c, hb_c;

    mfrf_ram #(
        .WIDTH (ID_W),
        .DEPTH (SEEN_DEPTH)
    ) u_seen (
        .clk   (clk),
        .we    (record),
        .waddr (slot_reg),
        .wdata (id_reg),
        .re    (dp_cmd.scan_step),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign dp_status.need_scan = (operation == OP_CLASSIFY) && (version == PROTO_VERSION)
                                 && auth_ok;
    assign dp_status.scan_last = (idx_reg == AW'(SEEN_DEPTH - 1));
    assign dp_status.out_free  = !out_valid_reg || out_ready;

    // entries past the fill count are treated as zero; the RAM itself is not reset
    assign entry_match = (FW'(cmp_idx_reg) < fill_reg) ? (rdata == id_reg)
                                                      : (id_reg == '0);

    assign to_me     = (dest_reg == my_addr_reg);
    assign to_bcast  = (dest_reg == ADDR_BCAST);
    assign may_relay = (origin_reg != my_addr_reg) && (limit_reg > 8'd1)
                       && ((type_reg == T_EMERGENCY) || to_bcast || !to_me);

    always_comb
    begin
        st_c       = ST_OK;
        deliver_c  = 1'b0;
        send_ack_c = 1'b0;
        relay_c    = 1'b0;
        ack_us_c   = 1'b0;
        hb_c       = 1'b0;
        if (op_reg == OP_RECORD)
        begin
            st_c = ST_LOCAL;
        end
        else if (ver_reg != PROTO_VERSION)
        begin
            st_c = ST_BAD_VERSION;
        end
        else if (!auth_reg)
        begin
            st_c = ST_AUTH_FAIL;
        end
        else if (hit_reg)
        begin
            st_c = ST_DUPLICATE;
        end
        else
        begin
            case (type_reg)
                T_DATA, T_FORWARD:
                begin
                    deliver_c  = to_me || to_bcast;
                    send_ack_c = (to_me || to_bcast) && ackreq_reg;
                    relay_c    = may_relay;
                end
                T_EMERGENCY:
                begin
                    deliver_c = 1'b1;
                    relay_c   = may_relay;
                end
                T_ACK:
                begin
                    relay_c  = !to_me && may_relay;
                    ack_us_c = to_me;
                end
                T_HEARTBEAT:
                begin
                    hb_c = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign record = dp_cmd.load_result && ((st_c == ST_OK) || (st_c == ST_LOCAL));

    always_comb
    begin
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        if (dp_cmd.capture)
        begin
            idx_next = '0;
            hit_next = 1'b0;
        end
        else if (dp_cmd.scan_step && !dp_status.scan_last)
        begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmp_valid_reg && entry_match)
        begin
            hit_next = 1'b1;
        end
        if (record)
        begin
            slot_next = (slot_reg == AW'(SEEN_DEPTH - 1)) ? '0 : slot_reg + AW'(1);
            if (fill_reg != FW'(SEEN_DEPTH))
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (dp_cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_addr_reg   <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                my_addr_reg <= cfg_wr_data;
            end
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= dp_cmd.scan_step;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg     <= operation;
            id_reg     <= message_id;
            ver_reg    <= version;
            auth_reg   <= auth_ok;
            type_reg   <= msg_type;
            origin_reg <= origin_addr;
            dest_reg   <= dest_addr;
            limit_reg  <= hop_limit;
            hops_reg   <= hops_taken;
            ackreq_reg <= ack_request;
        end
        if (dp_cmd.scan_step)
        begin
            cmp_idx_reg <= idx_reg;
        end
        if (dp_cmd.load_result)
        begin
            status_reg   <= st_c;
            deliver_reg  <= deliver_c;
            send_ack_reg <= send_ack_c;
            relay_reg    <= relay_c;
            ack_us_reg   <= ack_us_c;
            hb_reg       <= hb_c;
            r_limit_reg  <= relay_c ? (limit_reg - 8'd1) : 8'd0;
            r_hops_reg   <= relay_c ? ((hops_reg == HOP_MAX) ? HOP_MAX : hops_reg + 8'd1)
                                    : 8'd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign deliver         = deliver_reg;
    assign send_ack        = send_ack_reg;
    assign relay           = relay_reg;
    assign relay_hop_limit = r_limit_reg;
    assign relay_hops      = r_hops_reg;
    assign ack_for_us      = ack_us_reg;
    assign heartbeat_seen  = hb_reg;

    `MFRF_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= FW'(SEEN_DEPTH))
    `MFRF_ASSERT_IMP(a_load_free, dp_cmd.load_result, !out_valid_reg || out_ready)
    `MFRF_ASSERT_NXT(a_dup_no_record, dp_cmd.load_result && st_c == ST_DUPLICATE,
                     $stable(fill_reg) && $stable(slot_reg))
    `MFRF_ASSERT_IMP(a_no_scan_overlap, dp_cmd.capture, !dp_cmd.scan_step && !cmp_valid_reg)

endmodule

/* sv/mesh_flood_relay_filter_top.sv */
// A received header that passes version and auth is scanned against the seen store, then
// goes through the drain and result states; any other item goes straight to the result state.
// The result is loaded once the output register is free. One item is held at a time; the
// scan walks the seen-id RAM read port one entry per cycle. A new item is taken while the
// previous result waits in the output register. Reset (rst_n low, asynchronous) empties
// the seen store through a fill count, so every entry reads as id 0; no clearing pass.
module mesh_flood_relay_filter_top
    import mfrf_pkg::*;
#(
    parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [ID_W-1:0]   message_id,
    input  logic [7:0]        version,
    input  logic              auth_ok,
    input  logic [2:0]        msg_type,
    input  logic [ADDR_W-1:0] origin_addr,
    input  logic [ADDR_W-1:0] dest_addr,
    input  logic [7:0]        hop_limit,
    input  logic [7:0]        hops_taken,
    input  logic              ack_request,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic              deliver,
    output logic              send_ack,
    output logic              relay,
    output logic [7:0]        relay_hop_limit,
    output logic [7:0]        relay_hops,
    output logic              ack_for_us,
    output logic              heartbeat_seen
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    mfrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    mfrf_dp #(
        .SEEN_DEPTH (SEEN_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .dp_status       (dp_status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .operation       (operation),
        .message_id      (message_id),
        .version         (version),
        .auth_ok         (auth_ok),
        .msg_type        (msg_type),
        .origin_addr     (origin_addr),
        .dest_addr       (dest_addr),
        .hop_limit       (hop_limit),
        .hops_taken      (hops_taken),
        .ack_request     (ack_request),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .deliver         (deliver),
        .send_ack        (send_ack),
        .relay           (relay),
        .relay_hop_limit (relay_hop_limit),
        .relay_hops      (relay_hops),
        .ack_for_us      (ack_for_us),
        .heartbeat_seen  (heartbeat_seen)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for mesh_flood_relay_filter_top: directed and random headers
// are checked against a seen-ring predictor, with bursty input and stalling output.
// Depends on mfrf_pkg and the mesh_flood_relay_filter_top RTL.
module tb_top;
    import mfrf_pkg::*;

    localparam int RANDOM_HEADERS = 1428;
    localparam int ADDR_PHASES    = 6;
    localparam logic [ADDR_W-1:0] OTHER_A = 48'h5A5A_1234_9876;
    localparam logic [ADDR_W-1:0] OTHER_B = 48'h0F0F_C3C3_0001;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   message_id;
        logic [7:0]        version;
        logic              auth_ok;
        logic [2:0]        msg_type;
        logic [ADDR_W-1:0] origin_addr;
        logic [ADDR_W-1:0] dest_addr;
        logic [7:0]        hop_limit;
        logic [7:0]        hops_taken;
        logic              ack_request;
    } hdr_t;

    typedef struct packed {
        logic [2:0] status;
        logic       deliver;
        logic       send_ack;
        logic       relay;
        logic [7:0] relay_hop_limit;
        logic [7:0] relay_hops;
        logic       ack_for_us;
        logic       heartbeat_seen;
    } verdict_t;

    class relay_verdict_board;
        logic [ADDR_W-1:0] node_addr;
        logic [ID_W-1:0]   seen_ring [SEEN_DEPTH_DEF];
        int unsigned       ring_slot;
        verdict_t          pending_verdicts[$];
        int                failures;
        int                status_tally[5];
        int                relays;

        function new();
            node_addr = '0;
            foreach (seen_ring[i])
                seen_ring[i] = '0;
            foreach (status_tally[i])
                status_tally[i] = 0;
            ring_slot = 0;
            failures  = 0;
            relays    = 0;
        endfunction

        function bit id_known(logic [ID_W-1:0] id);
            foreach (seen_ring[i])
                if (seen_ring[i] == id)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_id(logic [ID_W-1:0] id);
            seen_ring[ring_slot] = id;
            ring_slot = (ring_slot + 1) % SEEN_DEPTH_DEF;
        endfunction

        function bit relay_allowed(hdr_t h);
            if (h.origin_addr == node_addr || h.hop_limit <= 8'd1)
                return 1'b0;
            if (h.msg_type == T_EMERGENCY || h.dest_addr == ADDR_BCAST)
                return 1'b1;
            return h.dest_addr != node_addr;
        endfunction

        function void take_header(hdr_t h);
            verdict_t v;
            v = '0;
            if (h.operation == OP_RECORD)
            begin
                note_id(h.message_id);
                v.status = ST_LOCAL;
            end
            else if (h.version != PROTO_VERSION)
                v.status = ST_BAD_VERSION;
            else if (!h.auth_ok)
                v.status = ST_AUTH_FAIL;
            else if (id_known(h.message_id))
                v.status = ST_DUPLICATE;
            else
            begin
                note_id(h.message_id);
                v.status = ST_OK;
                case (h.msg_type)
                    T_DATA, T_FORWARD:
                    begin
                        if (h.dest_addr == node_addr || h.dest_addr == ADDR_BCAST)
                        begin
                            v.deliver  = 1'b1;
                            v.send_ack = h.ack_request;
                        end
                        v.relay = relay_allowed(h);
                    end
                    T_EMERGENCY:
                    begin
                        v.deliver = 1'b1;
                        v.relay   = relay_allowed(h);
                    end
                    T_ACK:
                    begin
                        if (h.dest_addr != node_addr)
                            v.relay = relay_allowed(h);
                        else
                            v.ack_for_us = 1'b1;
                    end
                    T_HEARTBEAT:
                        v.heartbeat_seen = 1'b1;
                    default:
                        ;
                endcase
                if (v.relay)
                begin
                    v.relay_hop_limit = h.hop_limit - 8'd1;
                    v.relay_hops = (h.hops_taken == HOP_MAX) ? HOP_MAX : h.hops_taken + 8'd1;
                end
            end
            status_tally[v.status]++;
            if (v.relay)
                relays++;
            pending_verdicts.insert(pending_verdicts.size(), v);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("result beat with no header outstanding");
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("deliver", 8'(want.deliver), 8'(got.deliver));
            compare_field("send_ack", 8'(want.send_ack), 8'(got.send_ack));
            compare_field("relay", 8'(want.relay), 8'(got.relay));
            compare_field("relay_hop_limit", want.relay_hop_limit, got.relay_hop_limit);
            compare_field("relay_hops", want.relay_hops, got.relay_hops);
            compare_field("ack_for_us", 8'(want.ack_for_us), 8'(got.ack_for_us));
            compare_field("heartbeat_seen", 8'(want.heartbeat_seen), 8'(got.heartbeat_seen));
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [ADDR_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic [ID_W-1:0]   message_id;
    logic [7:0]        version;
    logic              auth_ok;
    logic [2:0]        msg_type;
    logic [ADDR_W-1:0] origin_addr;
    logic [ADDR_W-1:0] dest_addr;
    logic [7:0]        hop_limit;
    logic [7:0]        hops_taken;
    logic              ack_request;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        status;
    logic              deliver;
    logic              send_ack;
    logic              relay;
    logic [7:0]        relay_hop_limit;
    logic [7:0]        relay_hops;
    logic              ack_for_us;
    logic              heartbeat_seen;

    relay_verdict_board board;
    logic [ID_W-1:0]    id_pool[$];
    int                 burst_left;
    int                 headers_sent;
    int                 addr_writes;

    mesh_flood_relay_filter_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .message_id      (message_id),
        .version         (version),
        .auth_ok         (auth_ok),
        .msg_type        (msg_type),
        .origin_addr     (origin_addr),
        .dest_addr       (dest_addr),
        .hop_limit       (hop_limit),
        .hops_taken      (hops_taken),
        .ack_request     (ack_request),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .deliver         (deliver),
        .send_ack        (send_ack),
        .relay           (relay),
        .relay_hop_limit (relay_hop_limit),
        .relay_hops      (relay_hops),
        .ack_for_us      (ack_for_us),
        .heartbeat_seen  (heartbeat_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] any_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    function automatic hdr_t make_header(logic op, logic [ID_W-1:0] id, logic [7:0] ver,
                                         logic auth, logic [2:0] kind,
                                         logic [ADDR_W-1:0] origin, logic [ADDR_W-1:0] dest,
                                         logic [7:0] limit, logic [7:0] hops, logic ackreq);
        hdr_t h;
        h.operation   = op;
        h.message_id  = id;
        h.version     = ver;
        h.auth_ok     = auth;
        h.msg_type    = kind;
        h.origin_addr = origin;
        h.dest_addr   = dest;
        h.hop_limit   = limit;
        h.hops_taken  = hops;
        h.ack_request = ackreq;
        return h;
    endfunction

    function automatic hdr_t random_header();
        hdr_t       h;
        int         pick;
        logic [7:0] limit_edge [4] = '{8'd0, 8'd1, 8'd2, 8'd255};
        logic [7:0] hops_edge [3]  = '{8'd0, 8'd254, 8'd255};
        h.operation = ($urandom_range(0, 99) < 15) ? OP_RECORD : OP_CLASSIFY;
        pick = $urandom_range(0, 99);
        if (pick < 40 || id_pool.size() == 0)
            h.message_id = $urandom;
        else if (pick < 92)
            h.message_id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else
            h.message_id = '0;
        if (h.message_id != '0)
        begin
            id_pool.insert(id_pool.size(), h.message_id);
            if (id_pool.size() > 48)
                void'(id_pool.pop_front());
        end
        h.version = ($urandom_range(0, 99) < 88) ? PROTO_VERSION : 8'($urandom_range(0, 255));
        h.auth_ok = ($urandom_range(0, 99) < 90);
        h.msg_type = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, 4))
                                                 : 3'($urandom_range(5, 7));
        h.origin_addr = ($urandom_range(0, 99) < 20) ? board.node_addr : any_addr();
        pick = $urandom_range(0, 99);
        if (pick < 25)
            h.dest_addr = board.node_addr;
        else if (pick < 50)
            h.dest_addr = ADDR_BCAST;
        else
            h.dest_addr = any_addr();
        h.hop_limit = ($urandom_range(0, 99) < 30) ? limit_edge[$urandom_range(0, 3)]
                                                  : 8'($urandom_range(0, 255));
        h.hops_taken = ($urandom_range(0, 99) < 20) ? hops_edge[$urandom_range(0, 2)]
                                                   : 8'($urandom_range(0, 255));
        h.ack_request = 1'($urandom_range(0, 1));
        return h;
    endfunction

    task automatic send_header(input hdr_t h);
        in_valid    <= 1'b1;
        operation   <= h.operation;
        message_id  <= h.message_id;
        version     <= h.version;
        auth_ok     <= h.auth_ok;
        msg_type    <= h.msg_type;
        origin_addr <= h.origin_addr;
        dest_addr   <= h.dest_addr;
        hop_limit   <= h.hop_limit;
        hops_taken  <= h.hops_taken;
        ack_request <= h.ack_request;
        do
            @(posedge clk);
        while (!in_ready);
        board.take_header(h);
        headers_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(13, 45)
                                                : $urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic set_node_address(input logic [ADDR_W-1:0] a);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.node_addr = a;
        addr_writes++;
    endtask

    initial
    begin
        int mode;
        int span;
        out_ready <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(4, 60);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_watch
        verdict_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.status          = status;
            got.deliver         = deliver;
            got.send_ack        = send_ack;
            got.relay           = relay;
            got.relay_hop_limit = relay_hop_limit;
            got.relay_hops      = relay_hops;
            got.ack_for_us      = ack_for_us;
            got.heartbeat_seen  = heartbeat_seen;
            board.check_verdict(got);
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] addr;
        board = new();
        headers_sent = 0;
        addr_writes  = 0;
        burst_left   = 0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        operation   <= OP_CLASSIFY;
        message_id  <= '0;
        version     <= '0;
        auth_ok     <= 1'b0;
        msg_type    <= T_DATA;
        origin_addr <= '0;
        dest_addr   <= '0;
        hop_limit   <= '0;
        hops_taken  <= '0;
        ack_request <= 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // node address still at its reset value of zero
        send_header(make_header(OP_CLASSIFY, 32'h0, PROTO_VERSION, 1'b1, T_DATA,
                                OTHER_A, ADDR_BCAST, 8'd5, 8'd0, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h0, 8'h00, 1'b0, T_DATA,
                                OTHER_A, ADDR_BCAST, 8'd5, 8'd0, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'hFFFF_FFFF, 8'hFF, 1'b1, T_DATA,
                                OTHER_A, ADDR_BCAST, 8'd5, 8'd0, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'hFFFF_FFFF, PROTO_VERSION, 1'b0, T_DATA,
                                OTHER_A, ADDR_BCAST, 8'd5, 8'd0, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'h10, 8'h02, 1'b0, T_FORWARD,
                                OTHER_A, ADDR_BCAST, 8'd5, 8'd0, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'hFFFF_FFFF, PROTO_VERSION, 1'b1, T_DATA,
                                OTHER_A, '0, 8'd5, 8'd3, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h11, PROTO_VERSION, 1'b1, T_DATA,
                                OTHER_A, ADDR_BCAST, 8'hFF, 8'hFF, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h12, PROTO_VERSION, 1'b1, T_FORWARD,
                                OTHER_A, OTHER_B, 8'd2, 8'hFE, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'h13, PROTO_VERSION, 1'b1, T_FORWARD,
                                OTHER_A, OTHER_B, 8'd1, 8'd7, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h14, PROTO_VERSION, 1'b1, T_DATA,
                                OTHER_A, ADDR_BCAST, 8'd0, 8'd0, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'h15, PROTO_VERSION, 1'b1, T_DATA,
                                '0, ADDR_BCAST, 8'd9, 8'd1, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h16, PROTO_VERSION, 1'b1, T_EMERGENCY,
                                OTHER_A, '0, 8'd3, 8'd0, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'h17, PROTO_VERSION, 1'b1, T_EMERGENCY,
                                '0, ADDR_BCAST, 8'd3, 8'd0, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h18, PROTO_VERSION, 1'b1, T_ACK,
                                OTHER_A, '0, 8'd6, 8'd2, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'h19, PROTO_VERSION, 1'b1, T_ACK,
                                OTHER_A, OTHER_B, 8'd4, 8'd2, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h1A, PROTO_VERSION, 1'b1, T_ACK,
                                OTHER_A, ADDR_BCAST, 8'd1, 8'd2, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'h1B, PROTO_VERSION, 1'b1, T_HEARTBEAT,
                                OTHER_A, ADDR_BCAST, 8'd8, 8'd0, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'h1C, PROTO_VERSION, 1'b1, 3'd5,
                                OTHER_A, ADDR_BCAST, 8'd8, 8'd0, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h1D, PROTO_VERSION, 1'b1, 3'd6,
                                OTHER_A, '0, 8'd8, 8'd0, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h1E, PROTO_VERSION, 1'b1, 3'd7,
                                OTHER_A, OTHER_B, 8'd8, 8'd0, 1'b0));
        send_header(make_header(OP_CLASSIFY, 32'h11, PROTO_VERSION, 1'b1, T_DATA,
                                OTHER_A, ADDR_BCAST, 8'd5, 8'd0, 1'b0));
        send_header(make_header(OP_RECORD, 32'h8000_0000, 8'hFF, 1'b0, 3'd7,
                                ADDR_BCAST, ADDR_BCAST, 8'hFF, 8'hFF, 1'b1));
        send_header(make_header(OP_RECORD, 32'h8000_0000, 8'hFF, 1'b0, 3'd7,
                                ADDR_BCAST, ADDR_BCAST, 8'hFF, 8'hFF, 1'b1));
        send_header(make_header(OP_CLASSIFY, 32'h8000_0000, PROTO_VERSION, 1'b1, T_DATA,
                                OTHER_A, ADDR_BCAST, 8'd5, 8'd0, 1'b0));
        send_header(make_header(OP_RECORD, 32'h0, 8'h00, 1'b0, T_DATA,
                                '0, '0, 8'h00, 8'h00, 1'b0));

        for (int p = 0; p < ADDR_PHASES; p++)
        begin
            case (p)
                0: addr = ADDR_BCAST;
                2: addr = '0;
                3: addr = 48'h1;
                5: addr = 48'h8000_0000_0000;
                default: addr = any_addr();
            endcase
            wait_idle();
            set_node_address(addr);
            repeat (RANDOM_HEADERS / ADDR_PHASES)
                send_header(random_header());
        end
        wait_idle();
        repeat (SEEN_DEPTH_DEF + 19)
            @(posedge clk);

        $display("Covered %0d headers under %0d node addresses: %0d accepted, %0d duplicates,",
                 headers_sent, addr_writes + 1, board.status_tally[ST_OK],
                 board.status_tally[ST_DUPLICATE]);
        $display("%0d bad version, %0d auth failures, %0d local records, %0d relayed.",
                 board.status_tally[ST_BAD_VERSION], board.status_tally[ST_AUTH_FAIL],
                 board.status_tally[ST_LOCAL], board.relays);
        if (board.failures == 0 && board.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
